// File: rtl/pip_pkg.sv
// pip_pkg: shared constants, payload types and helper functions for the
// pinhole intrinsics projection pipeline
// no dependencies
package pip_pkg;

    // fixed point format
    localparam int FRAC_BITS = 16;

    // divider geometry: dividend magnitude, divisor, quotient bits, result
    localparam int NUM_W   = 64;
    localparam int DEN_W   = 32;
    localparam int QUO_W   = 34;
    localparam int RES_W   = QUO_W + 2;
    localparam int DIV_LAT = QUO_W + 2;

    // configuration register indexes
    localparam logic [2:0] CFG_FOCAL  = 3'd0;
    localparam logic [2:0] CFG_ASPECT = 3'd1;
    localparam logic [2:0] CFG_SKEW   = 3'd2;
    localparam logic [2:0] CFG_CX     = 3'd3;
    localparam logic [2:0] CFG_CY     = 3'd4;

    // operation codes
    typedef logic [1:0] t_op;
    localparam t_op OP_MAP2  = 2'd0;
    localparam t_op OP_MAP3  = 2'd1;
    localparam t_op OP_UNMAP = 2'd2;

    // 1.0 and rounding half in fixed point
    localparam logic [30:0]        ONE_UQ     = 31'(1) << FRAC_BITS;
    localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

    // word carried beside the first divider
    typedef struct packed {
        t_op                op;
        logic               zf;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [32:0] px;
    } t_side1;

    // word carried beside the second divider
    typedef struct packed {
        t_op                op;
        logic               zf;
        logic signed [31:0] ox_map;
        logic signed [31:0] yn;
    } t_side2;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // magnitude of a signed 32-bit value, most negative fits as unsigned
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? (~v + 32'd1) : v;
        return r;
    endfunction

    // a zero register used as a divisor counts as one lsb
    function automatic logic [DEN_W-1:0] divisor_of(input logic [30:0] r);
        logic [DEN_W-1:0] d;
        d = (r == 31'd0) ? DEN_W'(1) : DEN_W'(r);
        return d;
    endfunction

endpackage

// File: rtl/pip_div.sv
// pip_div: pipelined restoring divider, one quotient bit per stage,
// truncating toward zero, quotient clamped past the quotient width
// depends on pip_pkg
module pip_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [pip_pkg::NUM_W-1:0]        i_num,
    input  logic [pip_pkg::DEN_W-1:0]        i_den,
    input  logic                             i_neg,
    output logic                             o_valid,
    output logic signed [pip_pkg::RES_W-1:0] o_quo
);

    localparam int QW = pip_pkg::QUO_W;
    localparam int DW = pip_pkg::DEN_W;
    localparam int NW = pip_pkg::NUM_W;
    localparam int RW = pip_pkg::RES_W;
    localparam logic [RW-1:0] OVF_MAG = RW'(1) << QW;

    logic          r_vld [0:QW];
    logic [DW-1:0] r_rem [0:QW];
    logic [QW-1:0] r_w   [0:QW];
    logic [DW-1:0] r_den [0:QW];
    logic          r_neg [0:QW];
    logic          r_ovf [0:QW];

    logic                 r_out_vld;
    logic signed [RW-1:0] r_quo;
    logic [RW-1:0]        mag;

    // entry: high dividend bits form the partial remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= DW'(i_num[NW-1:QW]);
        r_w[0]   <= i_num[QW-1:0];
        r_den[0] <= i_den;
        r_neg[0] <= i_neg;
        r_ovf[0] <= DW'(i_num[NW-1:QW]) >= i_den;
    end

    // one compare-subtract per stage
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;

        assign trial = {r_rem[k], r_w[k][QW-1]};
        assign diff  = trial - {1'b0, r_den[k]};
        assign ge    = trial >= {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_w[k+1]   <= {r_w[k][QW-2:0], ge};
            r_den[k+1] <= r_den[k];
            r_neg[k+1] <= r_neg[k];
            r_ovf[k+1] <= r_ovf[k];
        end
    end

    // apply sign, clamp an oversized quotient
    assign mag = r_ovf[QW] ? OVF_MAG : RW'(r_w[QW]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= r_neg[QW] ? -$signed(mag) : $signed(mag);
    end

    assign o_valid = r_out_vld;
    assign o_quo   = r_quo;

endmodule

// File: rtl/pinhole_intrinsics_projection_top.sv
// pinhole_intrinsics_projection_top: map, 3D map and unmap of points through
// pinhole intrinsics; front stages, two divider pipelines, output register
// depends on pip_pkg and pip_div
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  command  | start, busy               | i_operation, i_in_x, i_in_y, i_in_z
//  result   | o_strobe (one cycle)      | o_out_x, o_out_y, o_divide_fault
//  config   | i_cfg_valid, o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one word per cycle; busy stays low, the pipeline never stops
// the result strobe is registered after three front stages, a 36-stage divider
// for x/z, y/z and the unmapped y, four middle stages, a second 36-stage divider
// for the y map and unmapped x, and one output stage
// reset clears valid bits and strobe, sets focal and aspect to 1.0 and
// clears the rest of the configuration; nothing stalls
module pinhole_intrinsics_projection_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_operation,
    input  logic signed [31:0] i_in_x,
    input  logic signed [31:0] i_in_y,
    input  logic signed [31:0] i_in_z,
    output logic               o_strobe,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic               o_divide_fault,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int FB = pip_pkg::FRAC_BITS;
    localparam int NW = pip_pkg::NUM_W;
    localparam int DW = pip_pkg::DEN_W;
    localparam int RW = pip_pkg::RES_W;
    localparam int DL = pip_pkg::DIV_LAT;

    // configuration registers
    logic [30:0]        r_focal;
    logic [30:0]        r_aspect;
    logic signed [31:0] r_skew;
    logic signed [31:0] r_cx;
    logic signed [31:0] r_cy;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal  <= pip_pkg::ONE_UQ;
            r_aspect <= pip_pkg::ONE_UQ;
            r_skew   <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pip_pkg::CFG_FOCAL:  r_focal  <= i_cfg_data[30:0];
                pip_pkg::CFG_ASPECT: r_aspect <= i_cfg_data[30:0];
                pip_pkg::CFG_SKEW:   r_skew   <= i_cfg_data;
                pip_pkg::CFG_CX:     r_cx     <= i_cfg_data;
                pip_pkg::CFG_CY:     r_cy     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: capture, offset by principal point
    logic               r_s1_vld;
    pip_pkg::t_op       r_s1_op;
    logic signed [31:0] r_s1_x, r_s1_y, r_s1_z;
    logic signed [32:0] r_s1_px, r_s1_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_op <= i_operation;
        r_s1_x  <= i_in_x;
        r_s1_y  <= i_in_y;
        r_s1_z  <= i_in_z;
        r_s1_px <= 33'(i_in_x) - 33'(r_cx);
        r_s1_py <= 33'(i_in_y) - 33'(r_cy);
    end

    // stage 2: py times aspect for unmap
    logic               r_s2_vld;
    pip_pkg::t_op       r_s2_op;
    logic signed [31:0] r_s2_x, r_s2_y, r_s2_z;
    logic signed [32:0] r_s2_px;
    logic signed [64:0] r_s2_pya;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_op  <= r_s1_op;
        r_s2_x   <= r_s1_x;
        r_s2_y   <= r_s1_y;
        r_s2_z   <= r_s1_z;
        r_s2_px  <= r_s1_px;
        r_s2_pya <= 65'(r_s1_py) * 65'($signed({1'b0, r_aspect}));
    end

    // stage 3: dividend magnitudes and signs for the first divider
    logic               r_s3_vld;
    logic [NW-1:0]      r_s3_num_a, r_s3_num_b;
    logic [DW-1:0]      r_s3_den_a, r_s3_den_b;
    logic               r_s3_neg_a, r_s3_neg_b;
    pip_pkg::t_side1    r_s3_side;

    logic [DW-1:0]      zmag;
    logic               zzero;
    logic signed [64:0] pya_neg;

    assign zzero   = (r_s2_z == 32'sd0);
    assign zmag    = zzero ? DW'(1) : DW'(pip_pkg::mag32(r_s2_z));
    assign pya_neg = -r_s2_pya;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_num_a <= '0;
        r_s3_den_a <= DW'(1);
        r_s3_neg_a <= 1'b0;
        r_s3_num_b <= '0;
        r_s3_den_b <= DW'(1);
        r_s3_neg_b <= 1'b0;
        case (r_s2_op)
            pip_pkg::OP_MAP3: begin
                r_s3_num_a <= NW'(pip_pkg::mag32(r_s2_x)) << FB;
                r_s3_den_a <= zmag;
                r_s3_neg_a <= r_s2_x[31] ^ r_s2_z[31];
                r_s3_num_b <= NW'(pip_pkg::mag32(r_s2_y)) << FB;
                r_s3_den_b <= zmag;
                r_s3_neg_b <= r_s2_y[31] ^ r_s2_z[31];
            end
            pip_pkg::OP_UNMAP: begin
                r_s3_num_b <= r_s2_pya[64] ? pya_neg[NW-1:0] : r_s2_pya[NW-1:0];
                r_s3_den_b <= pip_pkg::divisor_of(r_focal);
                r_s3_neg_b <= r_s2_pya[64];
            end
            default: ;
        endcase
        r_s3_side.op <= r_s2_op;
        r_s3_side.zf <= zzero;
        r_s3_side.x  <= r_s2_x;
        r_s3_side.y  <= r_s2_y;
        r_s3_side.px <= r_s2_px;
    end

    // first divider pair with its side word delay line
    logic                 d1a_vld, d1b_vld;
    logic signed [RW-1:0] d1a_quo, d1b_quo;
    pip_pkg::t_side1      r_sb1 [DL];

    pip_div u_div1a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_vld),
        .i_num   (r_s3_num_a),
        .i_den   (r_s3_den_a),
        .i_neg   (r_s3_neg_a),
        .o_valid (d1a_vld),
        .o_quo   (d1a_quo)
    );

    pip_div u_div1b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_vld),
        .i_num   (r_s3_num_b),
        .i_den   (r_s3_den_b),
        .i_neg   (r_s3_neg_b),
        .o_valid (d1b_vld),
        .o_quo   (d1b_quo)
    );

    always_ff @(posedge i_clk) begin
        r_sb1[0] <= r_s3_side;
        for (int k = 1; k < DL; k++) begin
            r_sb1[k] <= r_sb1[k-1];
        end
    end

    // stage 4: pick the point fed to the multipliers
    logic               r_s4_vld;
    pip_pkg::t_op       r_s4_op;
    logic               r_s4_zf;
    logic signed [31:0] r_s4_x2, r_s4_y2;
    logic signed [32:0] r_s4_px;
    pip_pkg::t_side1    sb1_out;
    logic signed [31:0] quo_u, quo_v;

    assign sb1_out = r_sb1[DL-1];
    assign quo_u   = pip_pkg::sat32(64'(d1a_quo));
    assign quo_v   = pip_pkg::sat32(64'(d1b_quo));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= d1a_vld && d1b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_op <= sb1_out.op;
        r_s4_zf <= sb1_out.zf;
        r_s4_px <= sb1_out.px;
        r_s4_x2 <= (sb1_out.op == pip_pkg::OP_MAP3) ? quo_u : sb1_out.x;
        // for unmap the second lane holds the unmapped y
        r_s4_y2 <= (sb1_out.op == pip_pkg::OP_MAP3 || sb1_out.op == pip_pkg::OP_UNMAP)
                   ? quo_v : sb1_out.y;
    end

    // stage 5: products with focal length and skew
    logic               r_s5_vld;
    pip_pkg::t_op       r_s5_op;
    logic               r_s5_zf;
    logic signed [31:0] r_s5_y2;
    logic signed [32:0] r_s5_px;
    logic signed [63:0] r_s5_pxf, r_s5_pys, r_s5_pyf;
    logic signed [31:0] focal_s;

    assign focal_s = $signed({1'b0, r_focal});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else begin
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_op  <= r_s4_op;
        r_s5_zf  <= r_s4_zf;
        r_s5_y2  <= r_s4_y2;
        r_s5_px  <= r_s4_px;
        r_s5_pxf <= 64'(r_s4_x2) * 64'(focal_s);
        r_s5_pys <= 64'(r_s4_y2) * 64'(r_skew);
        r_s5_pyf <= 64'(r_s4_y2) * 64'(focal_s);
    end

    // stage 6: x product sum with rounding, second dividend
    logic               r_s6_vld;
    pip_pkg::t_op       r_s6_op;
    logic               r_s6_zf;
    logic signed [31:0] r_s6_yn;
    logic signed [63:0] r_s6_sum;
    logic signed [64:0] r_s6_num;
    logic [DW-1:0]      r_s6_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else begin
            r_s6_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_op  <= r_s5_op;
        r_s6_zf  <= r_s5_zf;
        r_s6_yn  <= r_s5_y2;
        r_s6_sum <= r_s5_pxf + r_s5_pys + pip_pkg::ROUND_HALF;
        if (r_s5_op == pip_pkg::OP_UNMAP) begin
            r_s6_num <= (65'(r_s5_px) <<< FB) - 65'(r_s5_pys);
            r_s6_den <= pip_pkg::divisor_of(r_focal);
        end else begin
            r_s6_num <= 65'(r_s5_pyf);
            r_s6_den <= pip_pkg::divisor_of(r_aspect);
        end
    end

    // stage 7: finish mapped x, magnitude for the second divider
    logic               r_s7_vld;
    logic [NW-1:0]      r_s7_num;
    logic [DW-1:0]      r_s7_den;
    logic               r_s7_neg;
    pip_pkg::t_side2    r_s7_side;
    logic signed [63:0] sum_sh;
    logic signed [64:0] num_neg;

    assign sum_sh  = r_s6_sum >>> FB;
    assign num_neg = -r_s6_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_vld <= 1'b0;
        end else begin
            r_s7_vld <= r_s6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s7_num         <= r_s6_num[64] ? num_neg[NW-1:0] : r_s6_num[NW-1:0];
        r_s7_den         <= r_s6_den;
        r_s7_neg         <= r_s6_num[64];
        r_s7_side.op     <= r_s6_op;
        r_s7_side.zf     <= r_s6_zf;
        r_s7_side.ox_map <= pip_pkg::sat32(sum_sh + 64'(r_cx));
        r_s7_side.yn     <= r_s6_yn;
    end

    // second divider with its side word delay line
    logic                 d2_vld;
    logic signed [RW-1:0] d2_quo;
    pip_pkg::t_side2      r_sb2 [DL];

    pip_div u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s7_vld),
        .i_num   (r_s7_num),
        .i_den   (r_s7_den),
        .i_neg   (r_s7_neg),
        .o_valid (d2_vld),
        .o_quo   (d2_quo)
    );

    always_ff @(posedge i_clk) begin
        r_sb2[0] <= r_s7_side;
        for (int k = 1; k < DL; k++) begin
            r_sb2[k] <= r_sb2[k-1];
        end
    end

    // output register: select per operation
    logic               r_strobe;
    logic signed [31:0] r_out_x, r_out_y;
    logic               r_fault;
    pip_pkg::t_side2    sb2_out;
    logic signed [31:0] oy_map, ox_unmap;

    assign sb2_out  = r_sb2[DL-1];
    assign oy_map   = pip_pkg::sat32(64'(d2_quo) + 64'(r_cy));
    assign ox_unmap = pip_pkg::sat32(64'(d2_quo));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_x <= '0;
        r_out_y <= '0;
        r_fault <= 1'b0;
        case (sb2_out.op)
            pip_pkg::OP_MAP2: begin
                r_out_x <= sb2_out.ox_map;
                r_out_y <= oy_map;
            end
            pip_pkg::OP_MAP3: begin
                // zero depth gives a zero point and the fault flag
                if (sb2_out.zf) begin
                    r_fault <= 1'b1;
                end else begin
                    r_out_x <= sb2_out.ox_map;
                    r_out_y <= oy_map;
                end
            end
            pip_pkg::OP_UNMAP: begin
                r_out_x <= ox_unmap;
                r_out_y <= sb2_out.yn;
            end
            default: ;
        endcase
    end

    assign o_strobe       = r_strobe;
    assign o_out_x        = r_out_x;
    assign o_out_y        = r_out_y;
    assign o_divide_fault = r_fault;

endmodule

// File: tb/tb_pinhole_intrinsics_projection_top.sv
// testbench for pinhole_intrinsics_projection_top: drives map, 3D map and
// unmap commands under several camera settings and checks every result word
// depends on pip_pkg and the rtl top level
`timescale 1ns / 100ps

module tb_pinhole_intrinsics_projection_top;

    localparam pip_pkg::t_op OP_SPARE  = 2'd3;
    localparam logic [2:0]   CFG_BAD_A = 3'd5;
    localparam logic [2:0]   CFG_BAD_B = 3'd7;
    localparam int           LIMIT     = 200000;
    localparam longint       ONE_FX    = 64'sd1 <<< pip_pkg::FRAC_BITS;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic               fault;
    } t_pixel;

    // camera model and queue of predicted pixel words
    class projection_board;
        logic        [30:0] focal;
        logic        [30:0] aspect;
        logic signed [31:0] skew;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        t_pixel             pending_q[$];
        int                 errors;

        function new();
            focal  = pip_pkg::ONE_UQ;
            aspect = pip_pkg::ONE_UQ;
            skew   = 0;
            cx     = 0;
            cy     = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                pip_pkg::CFG_FOCAL:  focal  = data[30:0];
                pip_pkg::CFG_ASPECT: aspect = data[30:0];
                pip_pkg::CFG_SKEW:   skew   = data;
                pip_pkg::CFG_CX:     cx     = data;
                pip_pkg::CFG_CY:     cy     = data;
                default: ;
            endcase
        endfunction

        function longint clamp(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint nonzero(logic [30:0] r);
            return (r == 0) ? 64'sd1 : longint'({33'd0, r});
        endfunction

        // normalized point to pixel
        function void map_point(longint x, longint y, output longint ox, output longint oy);
            longint f;
            longint sum;
            f   = longint'({33'd0, focal});
            sum = x * f + y * longint'(skew);
            ox  = clamp(((sum + pip_pkg::ROUND_HALF) >>> pip_pkg::FRAC_BITS)
                        + longint'(cx));
            oy  = clamp((y * f) / nonzero(aspect) + longint'(cy));
        endfunction

        function void note_input(pip_pkg::t_op op, logic signed [31:0] x,
                                 logic signed [31:0] y, logic signed [31:0] z);
            longint ox;
            longint oy;
            longint u;
            longint v;
            longint px;
            longint py;
            t_pixel w;
            ox = 0;
            oy = 0;
            w.fault = 1'b0;
            case (op)
                pip_pkg::OP_MAP2: map_point(longint'(x), longint'(y), ox, oy);
                pip_pkg::OP_MAP3: begin
                    if (z == 0) begin
                        w.fault = 1'b1;
                    end else begin
                        u = clamp((longint'(x) * ONE_FX) / longint'(z));
                        v = clamp((longint'(y) * ONE_FX) / longint'(z));
                        map_point(u, v, ox, oy);
                    end
                end
                pip_pkg::OP_UNMAP: begin
                    px = longint'(x) - longint'(cx);
                    py = longint'(y) - longint'(cy);
                    oy = clamp((py * longint'({33'd0, aspect})) / nonzero(focal));
                    ox = clamp((px * ONE_FX - oy * longint'(skew)) / nonzero(focal));
                end
                default: ;
            endcase
            w.px = ox[31:0];
            w.py = oy[31:0];
            pending_q.push_back(w);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic signed [31:0] ox, logic signed [31:0] oy, logic fault);
            t_pixel w;
            if (pending_q.size() == 0) begin
                report("result word with nothing expected");
            end else begin
                w = pending_q.pop_front();
                if (ox !== w.px) report($sformatf("out_x %h want %h", ox, w.px));
                if (oy !== w.py) report($sformatf("out_y %h want %h", oy, w.py));
                if (fault !== w.fault)
                    report($sformatf("divide_fault %b want %b", fault, w.fault));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_operation;
    logic signed [31:0] i_in_x;
    logic signed [31:0] i_in_y;
    logic signed [31:0] i_in_z;
    logic               o_strobe;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic               o_divide_fault;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    projection_board board;
    int              cycles;
    bit              quiet;

    pinhole_intrinsics_projection_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // accept monitor and result check
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            board.note_input(i_operation, i_in_x, i_in_y, i_in_z);
        if (i_rst_n && o_strobe)
            board.check_result(o_out_x, o_out_y, o_divide_fault);
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task send(pip_pkg::t_op op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        start       <= 1'b1;
        i_operation <= op;
        i_in_x      <= x;
        i_in_y      <= y;
        i_in_z      <= z;
        do @(posedge i_clk); while (busy);
    endtask

    task pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task cfg_write(logic [2:0] idx, logic [31:0] data);
        start       <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task drain();
        pause(1);
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task set_camera(logic [31:0] f, logic [31:0] a, logic [31:0] s, logic [31:0] x,
                    logic [31:0] y);
        cfg_write(pip_pkg::CFG_FOCAL, f);
        cfg_write(pip_pkg::CFG_ASPECT, a);
        cfg_write(pip_pkg::CFG_SKEW, s);
        cfg_write(pip_pkg::CFG_CX, x);
        cfg_write(pip_pkg::CFG_CY, y);
    endtask

    function logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
        endcase
    endfunction

    // random words, with bursts of idling unless quiet
    task random_words(int n);
        pip_pkg::t_op op;
        logic [31:0]  z;
        repeat (n) begin
            op = ($urandom_range(0, 19) == 0) ? OP_SPARE
                                              : pip_pkg::t_op'($urandom_range(0, 2));
            z  = ($urandom_range(0, 9) == 0) ? 32'd0 : rand_coord();
            send(op, rand_coord(), rand_coord(), z);
            if (!quiet && $urandom_range(0, 3) == 0) pause($urandom_range(1, 10));
        end
    endtask

    initial begin
        board       = new();
        quiet       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_operation = pip_pkg::OP_MAP2;
        i_in_x      = 0;
        i_in_y      = 0;
        i_in_z      = 0;
        i_cfg_valid = 1'b0;
        i_cfg_index = pip_pkg::CFG_FOCAL;
        i_cfg_data  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset camera, extremes of every operation
        send(pip_pkg::OP_MAP2, 32'h0001_0000, 32'hFFFF_0000, 0);
        send(pip_pkg::OP_MAP2, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send(pip_pkg::OP_MAP3, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
        send(pip_pkg::OP_MAP3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send(pip_pkg::OP_MAP3, 32'h0005_0000, 32'h0005_0000, 0);
        send(pip_pkg::OP_MAP3, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        send(pip_pkg::OP_UNMAP, 32'h0010_0000, 32'hFFF0_0000, 0);
        send(pip_pkg::OP_UNMAP, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send(OP_SPARE, 32'h1234_5678, 32'h8765_4321, 0);
        drain();

        // directed: extreme camera
        set_camera(32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send(pip_pkg::OP_MAP2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send(pip_pkg::OP_MAP2, 32'h8000_0000, 32'h0000_0001, 0);
        send(pip_pkg::OP_MAP3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send(pip_pkg::OP_UNMAP, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send(pip_pkg::OP_UNMAP, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        drain();

        // directed: zero focal and aspect used as one lsb, ignored indexes
        set_camera(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000);
        cfg_write(CFG_BAD_A, 32'hFFFF_FFFF);
        cfg_write(CFG_BAD_B, 32'h0000_1234);
        send(pip_pkg::OP_MAP2, 32'h0003_0000, 32'h0004_0000, 0);
        send(pip_pkg::OP_MAP3, 32'h0003_0000, 32'h0004_0000, 32'h0002_0000);
        send(pip_pkg::OP_UNMAP, 32'h0003_0000, 32'h0004_0000, 0);
        send(pip_pkg::OP_UNMAP, 32'h8000_0000, 32'h8000_0000, 0);
        drain();

        // random phases over several camera settings
        set_camera(32'h0001_0000, 32'h0001_0000, 0, 0, 0);
        random_words(100);
        drain();
        set_camera(32'h0320_0000, 32'h0001_2000, 32'h0000_0800, 32'h0140_0000, 32'h00F0_0000);
        random_words(100);
        drain();
        set_camera(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        random_words(100);
        drain();
        set_camera(32'h0000_0001, 32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        random_words(100);
        drain();
        set_camera($urandom, $urandom, $urandom, $urandom, $urandom);
        random_words(100);
        drain();
        quiet = 1'b1;
        set_camera($urandom, $urandom, $urandom, $urandom, $urandom);
        random_words(100);

        // drain the pipeline
        pause(1);
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (90) @(posedge i_clk);
        if (board.errors == 0 && board.pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
